// ===== rtl/stc_pkg.sv =====
`default_nettype none

package stc_pkg;

	localparam int X_W      = 16;
	localparam int Y_W      = 17;
	localparam int THR_W    = 16;
	localparam int TERMS_W  = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 16;
	localparam int SUM_W    = 48;
	localparam int ACC_W    = 54;
	localparam int D_W      = 49;
	localparam int DQ_W     = 56;

	localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SERIES_TERMS    = 2'd1;

	localparam logic [THR_W-1:0]   THR_RESET   = 16'd26624;
	localparam logic [TERMS_W-1:0] TERMS_RESET = 7'd100;

	localparam logic signed [SUM_W-1:0] SUM_ONE = 48'sd16777216;
	localparam logic signed [ACC_W-1:0] ACC_ONE = 54'sd16777216;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 54'sd140737488355327;
	localparam logic signed [ACC_W-1:0] ACC_MIN = -54'sd140737488355327;
	localparam logic signed [D_W-1:0]   D_ONE   = 49'sd16777216;

	localparam logic signed [D_W-1:0] RCP_SAT_LIMIT = 49'sd16776960;
	localparam logic [SUM_W-1:0]      RCP_REM_INIT  = 48'd8388608;
	localparam logic [Y_W-1:0]        Y_ONE         = 17'd65536;
	localparam logic [Y_W-1:0]        Y_ZERO        = 17'd0;

	localparam logic [2:0] DIV_LAST = 3'd6;
	localparam logic [4:0] RCP_LAST = 5'd16;

	typedef enum logic [1:0] {
		YSEL_CLAMP,
		YSEL_SPECIAL,
		YSEL_QUOT
	} ysel_t;

	typedef struct packed {
		logic  load;
		logic  mul;
		logic  div;
		logic  add;
		logic  rset;
		logic  rstep;
		logic  emit;
		ysel_t ysel;
	} cmd_t;

	typedef struct packed {
		logic above;
		logic below;
		logic i_zero;
		logic i_one;
		logic div_last;
		logic special;
		logic rcp_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/sigmoid_taylor_series_core.sv =====
// Sigmoid of a signed Q5.11 word by truncated Taylor series of e^-x.
// Raise start with x_in valid; the word is taken at the edge where start is
// high and busy is low, and busy stays high until the result is out.
// The result word (y_out, unsigned Q1.16, and clamped) is on the ports for
// one cycle with done high; the receiver must take it then, it cannot stall.
// A new start is taken in the same cycle that done is high.
// After the accepting edge the threshold is checked; when it clamps, the
// clamped result is emitted. Otherwise come series_terms-1 Horner steps
// (none for 0 or 1 terms), then the denominator check: out of the reciprocal's
// range it gives result 0 or 1.0, else the reciprocal runs. Each Horner step
// is the shared 47x16 multiply, then the divide by the step index at 8
// quotient bits a cycle until all 56 quotient bits are in, then the add and
// saturate. The final reciprocal is one bit a cycle, 17 quotient bits.
// One word is in flight at a time.
// Configuration: cfg_we with cfg_idx 0 writes clamp_threshold, 1 writes
// series_terms; other indexes are ignored. Write only while busy is low.
// Reset (arst_n low) sets clamp_threshold to 13.0 and series_terms to 100,
// clears busy and done.
`default_nettype none

module sigmoid_taylor_series_core
	import stc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic signed [X_W-1:0] x_in,
	output logic                       done,
	output logic [Y_W-1:0]             y_out,
	output logic                       clamped
);

	cmd_t cmd;
	sts_t sts;

	stc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	stc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.x_in     (x_in),
		.cmd      (cmd),
		.sts      (sts),
		.done     (done),
		.y_out    (y_out),
		.clamped  (clamped)
	);

`ifndef SYNTHESIS
	a_start_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle : assert property (@(posedge clk) disable iff (!arst_n)
		!(done && busy))
		else $error("result delivered while still busy");

	a_done_pulse : assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_clamp_value : assert property (@(posedge clk) disable iff (!arst_n)
		(done && clamped) |-> (y_out == Y_ZERO || y_out == Y_ONE))
		else $error("clamped result not 0 or 1.0");
`endif

endmodule

`default_nettype wire

// ===== rtl/stc_ctrl.sv =====
`default_nettype none

module stc_ctrl
	import stc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_DIV,
		S_ADD,
		S_RSET,
		S_RCP,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   busy_q;

	always_comb begin
		cmd        = '0;
		cmd.ysel   = YSEL_QUOT;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.above || sts.below) begin
					cmd.emit   = 1'b1;
					cmd.ysel   = YSEL_CLAMP;
					state_next = S_IDLE;
				end else if (sts.i_zero) begin
					state_next = S_RSET;
				end else begin
					state_next = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul    = 1'b1;
				state_next = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_last) begin
					state_next = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add    = 1'b1;
				state_next = sts.i_one ? S_RSET : S_MUL;
			end
			S_RSET: begin
				if (sts.special) begin
					cmd.emit   = 1'b1;
					cmd.ysel   = YSEL_SPECIAL;
					state_next = S_IDLE;
				end else begin
					cmd.rset   = 1'b1;
					state_next = S_RCP;
				end
			end
			S_RCP: begin
				cmd.rstep = 1'b1;
				if (sts.rcp_last) begin
					state_next = S_FIN;
				end
			end
			S_FIN: begin
				cmd.emit   = 1'b1;
				cmd.ysel   = YSEL_QUOT;
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			busy_q  <= (state_next != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

// ===== rtl/stc_datapath.sv =====
`default_nettype none

module stc_datapath
	import stc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic signed [X_W-1:0] x_in,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	output logic                      done,
	output logic [Y_W-1:0]            y_out,
	output logic                      clamped
);

	logic [THR_W-1:0]         thr_q;
	logic [TERMS_W-1:0]       terms_q;
	logic signed [X_W-1:0]    x_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [TERMS_W-1:0]       i_q;
	logic [DQ_W-1:0]          dq_q;
	logic [TERMS_W-1:0]       rem_q;
	logic                     neg_q;
	logic [2:0]               chunk_q;
	logic [SUM_W-1:0]         rrem_q;
	logic [Y_W-1:0]           rq_q;
	logic [4:0]               rbit_q;
	logic [Y_W-1:0]           y_q;
	logic                     clamped_q;
	logic                     done_q;

	logic signed [X_W+1:0]    x_ext_w;
	logic signed [X_W+1:0]    thr_ext_w;
	logic [X_W-1:0]           mx_w;
	logic [SUM_W-1:0]         sabs_w;
	logic [SUM_W-2:0]         ms_w;
	logic [62:0]              prod_w;
	logic [7:0]               qb_w;
	logic [TERMS_W-1:0]       rem_next_w;
	logic signed [ACC_W-1:0]  term_w;
	logic signed [ACC_W-1:0]  acc_w;
	logic signed [SUM_W-1:0]  sum_next_w;
	logic signed [D_W-1:0]    d_w;
	logic [D_W-1:0]           rt_w;
	logic [D_W-1:0]           dd_w;
	logic                     rge_w;
	logic [D_W-1:0]           rdiff_w;
	logic [Y_W-1:0]           y_sel_w;

	assign x_ext_w   = {{2{x_q[X_W-1]}}, x_q};
	assign thr_ext_w = $signed({2'b00, thr_q});

	assign mx_w   = x_q[X_W-1] ? X_W'(-x_q) : X_W'(x_q);
	assign sabs_w = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign ms_w   = sabs_w[SUM_W-2:0];
	assign prod_w = ms_w * mx_w;

	always_comb begin
		logic [7:0]         t;
		logic [TERMS_W-1:0] r;
		r    = rem_q;
		qb_w = '0;
		for (int k = 0; k < 8; k++) begin
			t = {r, dq_q[DQ_W-1-k]};
			if (t >= {1'b0, i_q}) begin
				r          = TERMS_W'(t - {1'b0, i_q});
				qb_w[7-k]  = 1'b1;
			end else begin
				r          = t[TERMS_W-1:0];
			end
		end
		rem_next_w = r;
	end

	always_comb begin
		term_w = $signed({2'b00, dq_q[51:0]});
		if (neg_q) begin
			term_w = -term_w;
		end
		acc_w = term_w + ACC_ONE;
		if (acc_w > ACC_MAX) begin
			sum_next_w = ACC_MAX[SUM_W-1:0];
		end else if (acc_w < ACC_MIN) begin
			sum_next_w = ACC_MIN[SUM_W-1:0];
		end else begin
			sum_next_w = acc_w[SUM_W-1:0];
		end
	end

	assign d_w     = $signed({sum_q[SUM_W-1], sum_q}) + D_ONE;
	assign rt_w    = {rrem_q, 1'b0};
	assign dd_w    = {1'b0, d_w[SUM_W-1:0]};
	assign rge_w   = (rt_w >= dd_w);
	assign rdiff_w = rt_w - dd_w;

	always_comb begin
		case (cmd.ysel)
			YSEL_CLAMP:   y_sel_w = (x_ext_w > thr_ext_w) ? Y_ONE : Y_ZERO;
			YSEL_SPECIAL: y_sel_w = d_w[D_W-1] ? Y_ZERO : Y_ONE;
			YSEL_QUOT:    y_sel_w = rq_q;
			default:      y_sel_w = Y_ZERO;
		endcase
	end

	assign sts.above    = (x_ext_w > thr_ext_w);
	assign sts.below    = (x_ext_w < -thr_ext_w);
	assign sts.i_zero   = (i_q == '0);
	assign sts.i_one    = (i_q == TERMS_W'(1));
	assign sts.div_last = (chunk_q == DIV_LAST);
	assign sts.special  = (d_w <= RCP_SAT_LIMIT);
	assign sts.rcp_last = (rbit_q == RCP_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			terms_q <= TERMS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_CLAMP_THRESHOLD: thr_q   <= cfg_data;
				CFG_SERIES_TERMS:    terms_q <= cfg_data[TERMS_W-1:0];
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= x_in;
			sum_q <= SUM_ONE;
			i_q   <= (terms_q == '0) ? '0 : terms_q - TERMS_W'(1);
		end
		if (cmd.mul) begin
			dq_q    <= {4'b0000, prod_w[62:11]};
			neg_q   <= sum_q[SUM_W-1] ^ ~x_q[X_W-1];
			rem_q   <= '0;
			chunk_q <= '0;
		end
		if (cmd.div) begin
			dq_q    <= {dq_q[DQ_W-9:0], qb_w};
			rem_q   <= rem_next_w;
			chunk_q <= chunk_q + 3'd1;
		end
		if (cmd.add) begin
			sum_q <= sum_next_w;
			i_q   <= i_q - TERMS_W'(1);
		end
		if (cmd.rset) begin
			rrem_q <= RCP_REM_INIT;
			rq_q   <= '0;
			rbit_q <= '0;
		end
		if (cmd.rstep) begin
			rrem_q <= rge_w ? rdiff_w[SUM_W-1:0] : rt_w[SUM_W-1:0];
			rq_q   <= {rq_q[Y_W-2:0], rge_w};
			rbit_q <= rbit_q + 5'd1;
		end
		if (cmd.emit) begin
			y_q       <= y_sel_w;
			clamped_q <= (cmd.ysel == YSEL_CLAMP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign done    = done_q;
	assign y_out   = y_q;
	assign clamped = clamped_q;

endmodule

`default_nettype wire
